### hw/rtl/opk_pkg.sv
// types and constants shared by the omega-phi-kappa rotation matrix block
package opk_pkg;

   typedef struct packed {
      logic signed [31:0] omega_angle;
      logic signed [31:0] phi_angle;
      logic signed [31:0] kappa_angle;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] r00;
      logic signed [31:0] r01;
      logic signed [31:0] r02;
      logic signed [31:0] r10;
      logic signed [31:0] r11;
      logic signed [31:0] r12;
      logic signed [31:0] r20;
      logic signed [31:0] r21;
      logic signed [31:0] r22;
   } rsp_word_type;

   // one CORDIC lane as it travels along the chain
   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic [1:0]         quad;
   } lane_type;

   localparam logic signed [63:0] PI_OVER_4_Q62 = 64'sh3243F6A8885A308D;
   localparam logic [63:0]        INV_SQRT2_Q62 = 64'h2D413CCCFE779921;
   localparam logic signed [63:0] HALF_PI_Q58   = 64'sh06487ED5110B4611;
   localparam int                 MAX_STAGES    = 62;

   // unsigned 64-bit quotient by shift and subtract (elaboration only)
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = 64'd0;
      rem = 65'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // arctangent of 2^-i in Q62, truncated series (elaboration only)
   function automatic logic signed [63:0] arctan_q62(input int i);
      logic signed [63:0] sum;
      logic signed [63:0] term;
      int e;
      sum = 64'sd0;
      if (i == 0) return PI_OVER_4_Q62;
      for (int k = 0; k < 64; k++) begin
         e = (2 * k + 1) * i;
         if (e > 62) break;
         term = $signed(udiv64(64'd1 << (62 - e), 64'(2 * k + 1)));
         sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      return sum;
   endfunction

   // CORDIC gain compensation in Q62 for n stages (elaboration only)
   function automatic logic signed [63:0] gain_q62(input int n);
      logic [63:0] g;
      logic [63:0] t;
      logic [63:0] acc;
      g = INV_SQRT2_Q62;
      t = 64'd0;
      acc = 64'd0;
      if (n == 0) return 64'sh4000000000000000;
      for (int i = 1; i < n; i++) begin
         if (2 * i <= 62) begin
            t = g;
            acc = g;
            for (int m = 1; m < 64; m++) begin
               t = t >> (2 * i);
               t = udiv64(t * 64'(2 * m - 1), 64'(2 * m));
               if (t == 64'd0) break;
               acc = (m % 2 == 1) ? acc - t : acc + t;
            end
            g = acc;
         end
      end
      return $signed(g);
   endfunction

endpackage

### hw/rtl/omega_phi_kappa_rotation_matrix.sv
// omega-phi-kappa rotation matrix: top level with CORDIC cell chain
// throughput: one word per cycle; busy is always low, set by the chain of
// CORDIC cells, one micro-rotation per cell per cycle for all three angles
// reset: synchronous active high reset clears only the valid pipeline;
// the receiver cannot stall, each result word shows for exactly one cycle
module omega_phi_kappa_rotation_matrix #(
   parameter int CORDIC_STAGES = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  opk_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output opk_pkg::rsp_word_type rsp_word
);
   // stages beyond 62 are unused by the arithmetic
   localparam int NST = (CORDIC_STAGES > opk_pkg::MAX_STAGES) ?
                        opk_pkg::MAX_STAGES : CORDIC_STAGES;
   // reduce 2, cells NST, matrix 4
   localparam int LAT = NST + 6;

   logic [31:0] angle_w [3];
   assign angle_w[0] = req_word.omega_angle;
   assign angle_w[1] = req_word.phi_angle;
   assign angle_w[2] = req_word.kappa_angle;

   opk_pkg::lane_type chain_w [NST + 1][3];

   opk_reduce #(.NSTAGES(NST)) u_reduce (
      .clock   (clock),
      .angle_in(angle_w),
      .lane_out(chain_w[0])
   );

   // the cell chain: one row of cells per angle lane
   for (genvar i = 0; i < NST; i++) begin : g_stage
      for (genvar j = 0; j < 3; j++) begin : g_lane
         opk_cell #(.STAGE(i)) u_cell (
            .clock   (clock),
            .lane_in (chain_w[i][j]),
            .lane_out(chain_w[i + 1][j])
         );
      end
   end

   opk_matrix u_matrix (
      .clock   (clock),
      .lane_in (chain_w[NST]),
      .word_out(rsp_word)
   );

   // valid travels alongside the data
   logic [LAT-1:0] valid_ff;
   logic [LAT-1:0] valid_in;
   assign valid_in = {valid_ff[LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign busy = 1'b0;
   assign rsp_valid = valid_ff[LAT-1];

   // a word accepted leaves at the end of the valid pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid) else $error("result word missing");
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT)) else $error("unexpected result word");
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
endmodule

### hw/rtl/opk_reduce.sv
// range reduction of three angles into CORDIC start lanes, two register stages
module opk_reduce #(
   parameter int NSTAGES = 28
) (
   input  logic                  clock,
   input  logic [31:0]           angle_in [3],
   output opk_pkg::lane_type     lane_out [3]
);
   localparam logic signed [63:0] X0 = opk_pkg::gain_q62(NSTAGES);
   localparam logic [63:0] H = opk_pkg::HALF_PI_Q58;

   // u = a*2^30 + 6.5h, u in [0, ~2^63); quotient below 16
   logic [63:0] u_ff [3];
   logic [63:0] u_in [3];
   logic [3:0]  q_w  [3];
   logic [63:0] rem_w [3];
   opk_pkg::lane_type lane_ff [3];
   opk_pkg::lane_type lane_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         u_in[j] = 64'($signed({{32{angle_in[j][31]}}, angle_in[j]}) <<< 30)
                   + 64'(6) * H + (H >> 1);
         // quotient by compare ladder over constant multiples of h
         q_w[j] = 4'd0;
         for (int m = 1; m < 16; m++) begin
            if (u_ff[j] >= 64'(m) * H) q_w[j] = 4'(m);
         end
         rem_w[j] = u_ff[j] - 64'(q_w[j]) * H;
         lane_in[j].x = X0;
         lane_in[j].y = 64'sd0;
         lane_in[j].z = ($signed(rem_w[j]) - $signed(H >> 1)) <<< 4;
         lane_in[j].quad = 2'(q_w[j] + 4'd2);
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      lane_ff <= lane_in;
   end

   assign lane_out = lane_ff;
endmodule

### hw/rtl/opk_cell.sv
// one CORDIC micro-rotation cell with a fixed shift and angle
module opk_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  opk_pkg::lane_type lane_in,
   output opk_pkg::lane_type lane_out
);
   localparam logic signed [63:0] ATAN = opk_pkg::arctan_q62(STAGE);
   opk_pkg::lane_type lane_ff;
   opk_pkg::lane_type next_in;
   logic signed [63:0] dx;
   logic signed [63:0] dy;

   always_comb begin
      dx = lane_in.y >>> STAGE;
      dy = lane_in.x >>> STAGE;
      next_in.quad = lane_in.quad;
      if (!lane_in.z[63]) begin
         next_in.x = lane_in.x - dx;
         next_in.y = lane_in.y + dy;
         next_in.z = lane_in.z - ATAN;
      end else begin
         next_in.x = lane_in.x + dx;
         next_in.y = lane_in.y - dy;
         next_in.z = lane_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= next_in;
   end

   assign lane_out = lane_ff;
endmodule

### hw/rtl/opk_matrix.sv
// quadrant fix-up, products and Q2.30 output of the rotation matrix
module opk_matrix (
   input  logic                  clock,
   input  opk_pkg::lane_type     lane_in [3],
   output opk_pkg::rsp_word_type word_out
);
   // Q31 values fit 33 bits signed
   typedef logic signed [32:0] q31_type;

   q31_type c_ff [3];
   q31_type s_ff [3];
   q31_type c_in [3];
   q31_type s_in [3];
   q31_type cr;
   q31_type sr;

   function automatic q31_type rnd31(input logic signed [63:0] v);
      logic signed [64:0] t;
      t = {v[63], v} + 65'sd1073741824;
      return q31_type'(t >>> 31);
   endfunction

   function automatic q31_type mul31(input q31_type a, input q31_type b);
      logic signed [65:0] p;
      p = a * b + 66'sd1073741824;
      return q31_type'(p >>> 31);
   endfunction

   function automatic logic signed [31:0] out30(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = (v + 36'sd1) >>> 1;
      if (t > 36'sd2147483647) return 32'sh7FFFFFFF;
      if (t < -36'sd2147483648) return 32'sh80000000;
      return 32'(t);
   endfunction

   always_comb begin
      cr = '0;
      sr = '0;
      for (int j = 0; j < 3; j++) begin
         cr = rnd31(lane_in[j].x);
         sr = rnd31(lane_in[j].y);
         case (lane_in[j].quad)
            2'd0: begin c_in[j] = cr;  s_in[j] = sr;  end
            2'd1: begin c_in[j] = -sr; s_in[j] = cr;  end
            2'd2: begin c_in[j] = -cr; s_in[j] = -sr; end
            default: begin c_in[j] = sr; s_in[j] = -cr; end
         endcase
      end
   end

   // stage a: sines and cosines
   always_ff @(posedge clock) begin
      c_ff <= c_in;
      s_ff <= s_in;
   end

   // stage b: pair products
   q31_type swsp_ff, cwsp_ff, cpck_ff, cpsk_ff, cwsk_ff, swsk_ff;
   q31_type cwck_ff, swck_ff, swcp_ff, cwcp_ff, sp_ff, ck_ff, sk_ff;
   always_ff @(posedge clock) begin
      swsp_ff <= mul31(s_ff[0], s_ff[1]);
      cwsp_ff <= mul31(c_ff[0], s_ff[1]);
      cpck_ff <= mul31(c_ff[1], c_ff[2]);
      cpsk_ff <= mul31(c_ff[1], s_ff[2]);
      cwsk_ff <= mul31(c_ff[0], s_ff[2]);
      swsk_ff <= mul31(s_ff[0], s_ff[2]);
      cwck_ff <= mul31(c_ff[0], c_ff[2]);
      swck_ff <= mul31(s_ff[0], c_ff[2]);
      swcp_ff <= mul31(s_ff[0], c_ff[1]);
      cwcp_ff <= mul31(c_ff[0], c_ff[1]);
      sp_ff   <= s_ff[1];
      ck_ff   <= c_ff[2];
      sk_ff   <= s_ff[2];
   end

   // stage c: triple products
   q31_type t01_ff, t02_ff, t11_ff, t12_ff;
   q31_type cpck2_ff, cpsk2_ff, cwsk2_ff, swsk2_ff, cwck2_ff, swck2_ff;
   q31_type swcp2_ff, cwcp2_ff, sp2_ff;
   always_ff @(posedge clock) begin
      t01_ff <= mul31(swsp_ff, ck_ff);
      t02_ff <= mul31(cwsp_ff, ck_ff);
      t11_ff <= mul31(swsp_ff, sk_ff);
      t12_ff <= mul31(cwsp_ff, sk_ff);
      cpck2_ff <= cpck_ff;
      cpsk2_ff <= cpsk_ff;
      cwsk2_ff <= cwsk_ff;
      swsk2_ff <= swsk_ff;
      cwck2_ff <= cwck_ff;
      swck2_ff <= swck_ff;
      swcp2_ff <= swcp_ff;
      cwcp2_ff <= cwcp_ff;
      sp2_ff   <= sp_ff;
   end

   // stage d: sums, rounding and clamp
   opk_pkg::rsp_word_type word_ff;
   always_ff @(posedge clock) begin
      word_ff.r00 <= out30(36'(cpck2_ff));
      word_ff.r01 <= out30(36'(cwsk2_ff) + 36'(t01_ff));
      word_ff.r02 <= out30(36'(swsk2_ff) - 36'(t02_ff));
      word_ff.r10 <= out30(-36'(cpsk2_ff));
      word_ff.r11 <= out30(36'(cwck2_ff) - 36'(t11_ff));
      word_ff.r12 <= out30(36'(swck2_ff) + 36'(t12_ff));
      word_ff.r20 <= out30(36'(sp2_ff));
      word_ff.r21 <= out30(-36'(swcp2_ff));
      word_ff.r22 <= out30(36'(cwcp2_ff));
   end

   assign word_out = word_ff;
endmodule
